@@ rtl/core/scl_archive_to_trdos_image_unit_defines.svh @@
// Assertion macros shared by the SCL to TR-DOS image converter.
`ifndef SCL_ARCHIVE_TO_TRDOS_IMAGE_UNIT_DEFINES_SVH
`define SCL_ARCHIVE_TO_TRDOS_IMAGE_UNIT_DEFINES_SVH

// property must hold at every clock edge out of reset
`define SCLTRD_ASSERT(label, prop, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
else $error(msg);

// condition must never be true
`define SCLTRD_NEVER(label, cond, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
else $error(msg);

`endif

@@ rtl/core/scltrd_pkg.sv @@
// Types, constants and helper functions of the SCL to TR-DOS image converter.
package scltrd_pkg;

	localparam int MAX_FILES         = 128;
	localparam int DATA_START_SECTOR = 16;
	localparam int MIN_ARCHIVE       = 24;
	localparam int MAX_SECTORS       = 4096;
	localparam int NORM_SECTORS      = 2560;
	localparam int NORM_CYLS         = 80;
	localparam int POS_W             = 5;
	localparam int QDEPTH            = 4;
	localparam int QPTR_W            = 2;
	localparam int STEPS             = 21;
	localparam int STEP_W            = 5;

	localparam logic [22:0] INFO_BASE = 23'h000800;

	localparam logic [4:0] STEP_WRITE  = 5'd0;
	localparam logic [4:0] STEP_SEC    = 5'd1;
	localparam logic [4:0] STEP_TRK    = 5'd2;
	localparam logic [4:0] STEP_INFO0  = 5'd3;
	localparam logic [4:0] STEP_STATUS = 5'd20;

	localparam logic [1:0] ST_MATCH    = 2'd0;
	localparam logic [1:0] ST_MISMATCH = 2'd1;
	localparam logic [1:0] ST_UNCHECK  = 2'd2;
	localparam logic [1:0] ST_INVALID  = 2'd3;

	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [6:0] {
		PH_MAGIC = 7'b0000001,
		PH_COUNT = 7'b0000010,
		PH_ENTRY = 7'b0000100,
		PH_DATA  = 7'b0001000,
		PH_SUM   = 7'b0010000,
		PH_TRAIL = 7'b0100000,
		PH_ERROR = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_file;
	} item_t;

	typedef struct packed {
		logic        record_kind;
		logic [22:0] image_address;
		logic [7:0]  image_byte;
		logic [1:0]  status_code;
		logic [7:0]  cylinder_count;
		logic        run_last;
	} rec_t;

	typedef struct packed {
		logic        has_wr;
		logic        ent_end;
		logic        eof;
		logic        ok;
		logic [22:0] wr_addr;
		logic [7:0]  wr_byte;
		logic [7:0]  ent;
		logic [15:0] ent_sec;
		logic [12:0] sec;
		logic [7:0]  files;
		logic [12:0] frei;
		logic [7:0]  cyl;
		logic [1:0]  st;
	} cmd_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic full;
		logic empty;
	} qctl_t;

	function automatic logic [7:0] mark_byte(input logic [2:0] i);
		logic [7:0] m;
		case (i)
			3'd0: m = 8'h53;
			3'd1: m = 8'h49;
			3'd2: m = 8'h4E;
			3'd3: m = 8'h43;
			3'd4: m = 8'h4C;
			3'd5: m = 8'h41;
			3'd6: m = 8'h49;
			default: m = 8'h52;
		endcase
		return m;
	endfunction

	// info sector byte offset for info steps
	function automatic logic [7:0] info_off(input logic [4:0] step);
		logic [7:0] o;
		if (step < 5'd10)
			o = 8'(step) + 8'd222;
		else if (step < 5'd19)
			o = 8'(step) + 8'd224;
		else
			o = 8'd244;
		return o;
	endfunction

endpackage

@@ rtl/core/scltrd_front.sv @@
// Archive parser: tracks format state per byte and issues expansion commands.
module scltrd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  scltrd_pkg::item_t   item,
	input  logic                q_full,
	output logic                q_push,
	output scltrd_pkg::cmd_t    q_cmd
);

	scltrd_pkg::phase_t phase_q, phase_n;
	logic [scltrd_pkg::POS_W-1:0] pos_q, pos_n;
	logic [7:0]  files_q, files_n, ent_q, ent_n;
	logic [3:0]  ebi_q, ebi_n;
	logic [15:0] nfs_q, nfs_n;
	logic [23:0] dbl_q, dbl_n;
	logic [31:0] rsum_q, rsum_n, ssum_q, ssum_n;
	logic        trail_q, trail_n;
	logic        accept;
	logic [7:0]  b;
	logic [13:0] sp;
	logic [7:0]  cyl;

	assign b          = item.data_byte;
	assign item_ready = !q_full;
	assign accept     = item_valid && item_ready;

	always_comb begin
		phase_n = phase_q;
		pos_n   = (pos_q == scltrd_pkg::POS_W'(scltrd_pkg::MIN_ARCHIVE)) ? pos_q : pos_q + 1'b1;
		files_n = files_q;
		ent_n   = ent_q;
		ebi_n   = ebi_q;
		nfs_n   = nfs_q;
		dbl_n   = dbl_q;
		rsum_n  = rsum_q;
		ssum_n  = ssum_q;
		trail_n = trail_q;
		q_cmd   = '0;
		case (phase_q)
			scltrd_pkg::PH_MAGIC: begin
				rsum_n = rsum_q + 32'(b);
				if (b != scltrd_pkg::mark_byte(ebi_q[2:0])) begin
					phase_n = scltrd_pkg::PH_ERROR;
				end else if (ebi_q[2:0] == 3'd7) begin
					ebi_n   = '0;
					phase_n = scltrd_pkg::PH_COUNT;
				end else begin
					ebi_n = ebi_q + 1'b1;
				end
			end
			scltrd_pkg::PH_COUNT: begin
				rsum_n  = rsum_q + 32'(b);
				files_n = b;
				if (b > 8'(scltrd_pkg::MAX_FILES)) begin
					phase_n = scltrd_pkg::PH_ERROR;
				end else if (b == 8'd0) begin
					ebi_n   = '0;
					phase_n = scltrd_pkg::PH_SUM;
				end else begin
					phase_n = scltrd_pkg::PH_ENTRY;
				end
			end
			scltrd_pkg::PH_ENTRY: begin
				rsum_n          = rsum_q + 32'(b);
				q_cmd.has_wr    = 1'b1;
				q_cmd.wr_addr   = 23'({ent_q, ebi_q});
				q_cmd.wr_byte   = b;
				if (ebi_q >= 4'd13) begin
					q_cmd.ent_end = 1'b1;
					q_cmd.ent     = ent_q;
					q_cmd.ent_sec = nfs_q;
					nfs_n         = nfs_q + 16'(b);
					ebi_n         = '0;
					ent_n         = ent_q + 1'b1;
					if (ent_n >= files_q) begin
						dbl_n   = {nfs_n - 16'(scltrd_pkg::DATA_START_SECTOR), 8'h00};
						phase_n = (dbl_n != '0) ? scltrd_pkg::PH_DATA : scltrd_pkg::PH_SUM;
					end
				end else begin
					ebi_n = ebi_q + 1'b1;
				end
			end
			scltrd_pkg::PH_DATA: begin
				rsum_n        = rsum_q + 32'(b);
				q_cmd.has_wr  = 1'b1;
				q_cmd.wr_addr = 23'({nfs_q, 8'h00} - dbl_q);
				q_cmd.wr_byte = b;
				dbl_n         = dbl_q - 1'b1;
				if (dbl_n == '0) begin
					ebi_n   = '0;
					phase_n = scltrd_pkg::PH_SUM;
				end
			end
			scltrd_pkg::PH_SUM: begin
				ssum_n = ssum_q | (32'(b) << {ebi_q[1:0], 3'b000});
				if (ebi_q[1:0] == 2'd3) begin
					ebi_n   = '0;
					phase_n = scltrd_pkg::PH_TRAIL;
				end else begin
					ebi_n = ebi_q + 1'b1;
				end
			end
			scltrd_pkg::PH_TRAIL: begin
				trail_n = 1'b1;
			end
			default: begin
			end
		endcase

		sp = 14'(nfs_n[12:0]) + 14'd31;
		cyl = (nfs_n <= 16'(scltrd_pkg::NORM_SECTORS)) ? 8'(scltrd_pkg::NORM_CYLS) : 8'(sp >> 5);
		q_cmd.eof   = item.end_of_file;
		q_cmd.ok    = (phase_n == scltrd_pkg::PH_TRAIL)
			&& (pos_n == scltrd_pkg::POS_W'(scltrd_pkg::MIN_ARCHIVE))
			&& (nfs_n <= 16'(scltrd_pkg::MAX_SECTORS));
		q_cmd.sec   = nfs_n[12:0];
		q_cmd.files = files_n;
		q_cmd.cyl   = cyl;
		q_cmd.frei  = {cyl, 5'b00000} - nfs_n[12:0];
		if (trail_n)
			q_cmd.st = scltrd_pkg::ST_UNCHECK;
		else
			q_cmd.st = (rsum_n == ssum_n) ? scltrd_pkg::ST_MATCH : scltrd_pkg::ST_MISMATCH;
	end

	assign q_push = accept && (q_cmd.has_wr || q_cmd.eof);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= scltrd_pkg::PH_MAGIC;
			pos_q   <= '0;
			files_q <= '0;
			ent_q   <= '0;
			ebi_q   <= '0;
			nfs_q   <= 16'(scltrd_pkg::DATA_START_SECTOR);
			dbl_q   <= '0;
			rsum_q  <= '0;
			ssum_q  <= '0;
			trail_q <= 1'b0;
		end else if (accept) begin
			if (item.end_of_file) begin
				phase_q <= scltrd_pkg::PH_MAGIC;
				pos_q   <= '0;
				files_q <= '0;
				ent_q   <= '0;
				ebi_q   <= '0;
				nfs_q   <= 16'(scltrd_pkg::DATA_START_SECTOR);
				dbl_q   <= '0;
				rsum_q  <= '0;
				ssum_q  <= '0;
				trail_q <= 1'b0;
			end else begin
				phase_q <= phase_n;
				pos_q   <= pos_n;
				files_q <= files_n;
				ent_q   <= ent_n;
				ebi_q   <= ebi_n;
				nfs_q   <= nfs_n;
				dbl_q   <= dbl_n;
				rsum_q  <= rsum_n;
				ssum_q  <= ssum_n;
				trail_q <= trail_n;
			end
		end
	end

endmodule

@@ rtl/core/scltrd_queue.sv @@
// Command queue between parser and record generator.
`include "scl_archive_to_trdos_image_unit_defines.svh"
module scltrd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  scltrd_pkg::cmd_t    wr_cmd,
	output scltrd_pkg::cmd_t    rd_cmd,
	input  logic                push,
	input  logic                pop,
	output logic                full,
	output logic                empty
);

	scltrd_pkg::cmd_t mem_q [scltrd_pkg::QDEPTH];
	logic [scltrd_pkg::QPTR_W-1:0] wp_q, rp_q;
	logic [scltrd_pkg::QPTR_W:0]   cnt_q;

	assign full   = (cnt_q == (scltrd_pkg::QPTR_W+1)'(scltrd_pkg::QDEPTH));
	assign empty  = (cnt_q == '0);
	assign rd_cmd = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + 1'b1;
			if (pop)
				rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (scltrd_pkg::QPTR_W+1)'(push) - (scltrd_pkg::QPTR_W+1)'(pop);
		end
	end

	`SCLTRD_NEVER(a_q_overflow, push && full && !pop, "queue push while full")
	`SCLTRD_NEVER(a_q_underflow, pop && empty, "queue pop while empty")
	`SCLTRD_ASSERT(a_q_count, cnt_q <= (scltrd_pkg::QPTR_W+1)'(scltrd_pkg::QDEPTH), "queue count out of range")

endmodule

@@ rtl/core/scltrd_back.sv @@
// Record generator: expands queued commands into image writes and status.
`include "scl_archive_to_trdos_image_unit_defines.svh"
module scltrd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  scltrd_pkg::cmd_t    cmd,
	input  logic                q_empty,
	output logic                q_pop,
	output logic                rec_valid,
	input  logic                rec_ready,
	output scltrd_pkg::rec_t    rec
);

	logic [scltrd_pkg::STEPS-1:0]  en, done_q, rem, cur;
	logic [scltrd_pkg::STEP_W-1:0] idx;
	logic                          last, load, rec_valid_q;
	scltrd_pkg::rec_t              rec_q, r;

	always_comb begin
		en = '0;
		en[scltrd_pkg::STEP_WRITE] = cmd.has_wr;
		en[scltrd_pkg::STEP_SEC]   = cmd.ent_end;
		en[scltrd_pkg::STEP_TRK]   = cmd.ent_end;
		for (int i = 3; i < 20; i++)
			en[i] = cmd.eof && cmd.ok;
		en[scltrd_pkg::STEP_STATUS] = cmd.eof;
	end

	assign rem  = en & ~done_q;
	assign cur  = rem & (~rem + 1'b1);
	assign last = ((rem & ~cur) == '0);
	assign load = !q_empty && (!rec_valid_q || rec_ready);
	assign q_pop = load && last;

	always_comb begin
		idx = '0;
		for (int i = 0; i < scltrd_pkg::STEPS; i++)
			if (cur[i])
				idx = scltrd_pkg::STEP_W'(i);
	end

	always_comb begin
		r = '0;
		r.record_kind = scltrd_pkg::KIND_WRITE;
		r.run_last    = last;
		case (idx)
			scltrd_pkg::STEP_WRITE: begin
				r.image_address = cmd.wr_addr;
				r.image_byte    = cmd.wr_byte;
			end
			scltrd_pkg::STEP_SEC: begin
				r.image_address = 23'({cmd.ent, 4'hE});
				r.image_byte    = {4'h0, cmd.ent_sec[3:0]};
			end
			scltrd_pkg::STEP_TRK: begin
				r.image_address = 23'({cmd.ent, 4'hF});
				r.image_byte    = cmd.ent_sec[11:4];
			end
			scltrd_pkg::STEP_STATUS: begin
				r.record_kind    = scltrd_pkg::KIND_STATUS;
				r.status_code    = cmd.ok ? cmd.st : scltrd_pkg::ST_INVALID;
				r.cylinder_count = cmd.ok ? cmd.cyl : 8'd0;
			end
			default: begin
				r.image_address = scltrd_pkg::INFO_BASE + 23'(scltrd_pkg::info_off(idx));
				case (idx - scltrd_pkg::STEP_INFO0)
					5'd0: r.image_byte = {4'h0, cmd.sec[3:0]};
					5'd1: r.image_byte = cmd.sec[11:4];
					5'd2: r.image_byte = 8'h16;
					5'd3: r.image_byte = cmd.files;
					5'd4: r.image_byte = cmd.frei[7:0];
					5'd5: r.image_byte = {3'b000, cmd.frei[12:8]};
					5'd6: r.image_byte = 8'h10;
					5'd16: r.image_byte = 8'h00;
					default: r.image_byte = 8'h20;
				endcase
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load)
			rec_q <= r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q <= 1'b0;
			done_q      <= '0;
		end else begin
			if (load) begin
				rec_valid_q <= 1'b1;
				done_q      <= last ? '0 : (done_q | cur);
			end else if (rec_ready) begin
				rec_valid_q <= 1'b0;
			end
		end
	end

	assign rec_valid = rec_valid_q;
	assign rec       = rec_q;

	`SCLTRD_ASSERT(a_status_last, rec_valid_q && rec_q.record_kind |-> rec_q.run_last, "status record not last")
	`SCLTRD_NEVER(a_done_subset, !q_empty && ((done_q & ~en) != '0), "consumed step outside command")

endmodule

@@ rtl/core/scl_archive_to_trdos_image_unit.sv @@
// SCL archive to TR-DOS image converter: one archive byte per cycle in; image
// write records and a final status record out at one record per cycle while
// rec_ready is high. Bytes that cause no record or one record sustain one byte
// per cycle. A catalog entry's last byte yields three records, and a valid
// final byte yields 18 (info sector writes plus status), so input stalls while
// the record generator drains them; a four-deep command queue between parser
// and generator absorbs bursts; commands and records are both registered.
module scl_archive_to_trdos_image_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  scltrd_pkg::item_t   item,
	output logic                rec_valid,
	input  logic                rec_ready,
	output scltrd_pkg::rec_t    rec
);

	scltrd_pkg::cmd_t  wr_cmd, rd_cmd;
	scltrd_pkg::qctl_t qctl;

	scltrd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_full     (qctl.full),
		.q_push     (qctl.push),
		.q_cmd      (wr_cmd)
	);

	scltrd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_cmd (wr_cmd),
		.rd_cmd (rd_cmd),
		.push   (qctl.push),
		.pop    (qctl.pop),
		.full   (qctl.full),
		.empty  (qctl.empty)
	);

	scltrd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (rd_cmd),
		.q_empty   (qctl.empty),
		.q_pop     (qctl.pop),
		.rec_valid (rec_valid),
		.rec_ready (rec_ready),
		.rec       (rec)
	);

endmodule

@@ sim/scl_archive_to_trdos_image_unit_tb.sv @@
// Testbench for the SCL archive to TR-DOS image converter: directed and random archives
// checked record by record against a behavioral model of the conversion.
module scl_archive_to_trdos_image_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	scltrd_pkg::item_t item = '0;
	logic rec_valid;
	logic rec_ready = 1'b0;
	scltrd_pkg::rec_t rec;

	scl_archive_to_trdos_image_unit dut (
		.clk(clk), .arst_n(arst_n), .item_valid(item_valid), .item_ready(item_ready),
		.item(item), .rec_valid(rec_valid), .rec_ready(rec_ready), .rec(rec)
	);

	always #5 clk = ~clk;

	// model state
	typedef enum int {M_MAGIC, M_COUNT, M_ENTRY, M_DATA, M_SUM, M_TRAIL, M_ERROR} mphase_t;
	mphase_t m_phase;
	int unsigned m_pos, m_files, m_ent, m_ebi, m_free, m_left, m_sum, m_stored;
	bit m_trail, m_err;

	scltrd_pkg::rec_t expected_recs[$];
	scltrd_pkg::rec_t last_rec;
	int last_cnt = 0;
	int errors = 0;
	int bytes_sent = 0;
	int archives_done = 0;
	int recs_checked = 0;
	int status_seen[4] = '{0, 0, 0, 0};
	bit quiet = 1'b0;

	function automatic logic [7:0] sig_char(int unsigned i);
		byte unsigned s[8] = '{8'h53, 8'h49, 8'h4E, 8'h43, 8'h4C, 8'h41, 8'h49, 8'h52};
		return s[i & 7];
	endfunction

	task automatic clear_converter();
		m_phase = M_MAGIC; m_pos = 0; m_files = 0; m_ent = 0; m_ebi = 0;
		m_free = scltrd_pkg::DATA_START_SECTOR; m_left = 0; m_sum = 0; m_stored = 0;
		m_trail = 0; m_err = 0;
	endtask

	task automatic push_wr(int unsigned a, int unsigned v);
		scltrd_pkg::rec_t r;
		r = '0;
		r.record_kind = scltrd_pkg::KIND_WRITE;
		r.image_address = a[22:0];
		r.image_byte = v[7:0];
		expected_recs.push_back(r);
	endtask

	task automatic push_status(logic [1:0] st, int unsigned cyl);
		scltrd_pkg::rec_t r;
		r = '0;
		r.record_kind = scltrd_pkg::KIND_STATUS;
		r.status_code = st;
		r.cylinder_count = cyl[7:0];
		expected_recs.push_back(r);
	endtask

	// converts one byte, appends expected records
	task automatic convert_byte(scltrd_pkg::item_t it);
		int unsigned b, n0, s, cyl, frei;
		logic [1:0] st;
		bit ok;
		b = it.data_byte;
		n0 = expected_recs.size();
		if (m_pos < 24'hFFFFFF) m_pos++;
		case (m_phase)
			M_MAGIC: begin
				m_sum += b;
				if (b != sig_char(m_ebi)) begin
					m_err = 1; m_phase = M_ERROR;
				end else if (++m_ebi >= 8) begin
					m_ebi = 0; m_phase = M_COUNT;
				end
			end
			M_COUNT: begin
				m_sum += b;
				m_files = b;
				if (b > scltrd_pkg::MAX_FILES) begin
					m_err = 1; m_phase = M_ERROR;
				end else if (b == 0) begin
					m_ebi = 0; m_phase = M_SUM;
				end else
					m_phase = M_ENTRY;
			end
			M_ENTRY: begin
				m_sum += b;
				push_wr(m_ent * 16 + m_ebi, b);
				if (m_ebi >= 13) begin
					push_wr(m_ent * 16 + 14, m_free & 8'h0F);
					push_wr(m_ent * 16 + 15, (m_free >> 4) & 8'hFF);
					m_free = (m_free + b) & 16'hFFFF;
					m_ebi = 0;
					m_ent = (m_ent + 1) & 8'hFF;
					if (m_ent >= m_files) begin
						m_left = ((m_free - scltrd_pkg::DATA_START_SECTOR) * 256) & 24'hFFFFFF;
						m_phase = m_left != 0 ? M_DATA : M_SUM;
					end
				end else
					m_ebi++;
			end
			M_DATA: begin
				m_sum += b;
				push_wr(m_free * 256 - m_left, b);
				m_left--;
				if (m_left == 0) begin
					m_ebi = 0; m_phase = M_SUM;
				end
			end
			M_SUM: begin
				m_stored |= b << (8 * (m_ebi & 3));
				if (++m_ebi >= 4) begin
					m_ebi = 0; m_phase = M_TRAIL;
				end
			end
			M_TRAIL: m_trail = 1;
			default: ;
		endcase
		if (it.end_of_file) begin
			ok = !m_err && m_phase == M_TRAIL && m_pos >= scltrd_pkg::MIN_ARCHIVE
				&& m_free <= scltrd_pkg::MAX_SECTORS;
			if (ok) begin
				s = m_free;
				cyl = s <= scltrd_pkg::NORM_SECTORS ? scltrd_pkg::NORM_CYLS : (s + 31) / 32;
				frei = cyl * 32 - s;
				push_wr(scltrd_pkg::INFO_BASE + 225, s & 8'h0F);
				push_wr(scltrd_pkg::INFO_BASE + 226, (s >> 4) & 8'hFF);
				push_wr(scltrd_pkg::INFO_BASE + 227, 8'h16);
				push_wr(scltrd_pkg::INFO_BASE + 228, m_files);
				push_wr(scltrd_pkg::INFO_BASE + 229, frei & 8'hFF);
				push_wr(scltrd_pkg::INFO_BASE + 230, (frei >> 8) & 8'hFF);
				push_wr(scltrd_pkg::INFO_BASE + 231, 8'h10);
				for (int k = 0; k < 9; k++) push_wr(scltrd_pkg::INFO_BASE + 234 + k, 8'h20);
				push_wr(scltrd_pkg::INFO_BASE + 244, 0);
				st = m_trail ? scltrd_pkg::ST_UNCHECK
					: (m_sum == m_stored ? scltrd_pkg::ST_MATCH : scltrd_pkg::ST_MISMATCH);
				push_status(st, cyl);
			end else
				push_status(scltrd_pkg::ST_INVALID, 0);
			archives_done++;
			clear_converter();
		end
		last_cnt = expected_recs.size() - n0;
		if (last_cnt > 0) begin
			expected_recs[$].run_last = 1'b1;
			last_rec = expected_recs[$];
		end
	endtask

	// stall bursts
	int src_gap = 0;
	int snk_gap = 0;

	task automatic send_byte(logic [7:0] b, logic eof);
		scltrd_pkg::item_t it;
		it.data_byte = b;
		it.end_of_file = eof;
		if (!quiet) begin
			if (src_gap == 0 && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 12);
			if (src_gap > 0) item_valid <= 1'b0;
			while (src_gap > 0) begin
				@(posedge clk);
				src_gap--;
			end
		end
		convert_byte(it);
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
		bytes_sent++;
	endtask

	// records out
	always @(posedge clk) begin
		if (arst_n) begin
			if (rec_valid && rec_ready) begin
				if (expected_recs.size() == 0) begin
					errors++;
					$display("%0t unexpected record: actual %p", $realtime, rec);
				end else begin
					scltrd_pkg::rec_t e;
					e = expected_recs.pop_front();
					recs_checked++;
					if (e.record_kind == scltrd_pkg::KIND_STATUS) status_seen[e.status_code]++;
					if (rec !== e) begin
						errors++;
						$display("%0t record mismatch: expected %p actual %p", $realtime, e, rec);
					end
				end
			end
			if (quiet) rec_ready <= 1'b1;
			else if (snk_gap > 0) begin
				snk_gap <= snk_gap - 1;
				rec_ready <= 1'b0;
			end else if ($urandom_range(0, 9) == 0) begin
				snk_gap <= $urandom_range(1, 12) - 1;
				rec_ready <= 1'b0;
			end else
				rec_ready <= 1'b1;
		end
	end

	int cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("scl_archive_to_trdos_image_unit: mismatch");
			$finish;
		end
	end

	task automatic send_header(int unsigned nfiles);
		for (int i = 0; i < 8; i++) send_byte(sig_char(i), 1'b0);
		send_byte(nfiles[7:0], 1'b0);
	endtask

	task automatic send_entry(logic [7:0] sectors, bit rnd);
		for (int i = 0; i < 13; i++) send_byte(rnd ? 8'($urandom) : 8'h41 + i[7:0], 1'b0);
		send_byte(sectors, 1'b0);
	endtask

	// sum of model so far plus tail: good, bad, or trailing bytes
	task automatic send_sum_tail(int kind);
		int unsigned s;
		int ntail;
		s = m_sum;
		if (kind == 1) s = s ^ (32'h1 << $urandom_range(0, 31));
		ntail = kind == 2 ? $urandom_range(1, 3) : 0;
		for (int i = 0; i < 4; i++) send_byte(s[8*i +: 8], i == 3 && ntail == 0);
		for (int i = 0; i < ntail; i++) send_byte(8'($urandom), i == ntail - 1);
	endtask

	// directed table
	typedef struct {
		logic [7:0] b;
		logic eof;
		logic chk;
		logic [1:0] st;
	} row_t;

	row_t dir_rows[5] = '{
		'{8'h00, 1'b1, 1'b1, scltrd_pkg::ST_INVALID},
		'{8'hFF, 1'b1, 1'b1, scltrd_pkg::ST_INVALID},
		'{8'h53, 1'b0, 1'b0, scltrd_pkg::ST_MATCH},
		'{8'h58, 1'b0, 1'b0, scltrd_pkg::ST_MATCH},
		'{8'hFF, 1'b1, 1'b1, scltrd_pkg::ST_INVALID}
	};

	task automatic random_archive();
		int unsigned nf, r;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			// noise
			for (int i = $urandom_range(1, 4); i > 0; i--) send_byte(8'($urandom), 1'b0);
			send_byte(8'($urandom), 1'b1);
			return;
		end
		nf = $urandom_range(0, 2);
		if (r < 18) nf = $urandom_range(129, 255);
		send_header(nf);
		if (nf > scltrd_pkg::MAX_FILES) begin
			send_byte(8'($urandom), 1'b1);
			return;
		end
		for (int f = 0; f < nf; f++)
			send_entry((r < 30 && f == 0) ? 8'd1 : 8'd0, 1'b1);
		// a data sector may be cut short by the end of the archive
		while (m_phase == M_DATA) begin
			if ($urandom_range(0, 7) == 0) begin
				send_byte(8'($urandom), 1'b1);
				return;
			end
			send_byte(8'($urandom), 1'b0);
		end
		send_sum_tail(r < 60 ? 0 : (r < 80 ? 1 : 2));
	endtask

	initial begin
		clear_converter();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) begin
			send_byte(dir_rows[i].b, dir_rows[i].eof);
			if (dir_rows[i].chk && (last_cnt != 1 ||
					last_rec.record_kind != scltrd_pkg::KIND_STATUS ||
					last_rec.status_code != dir_rows[i].st)) begin
				errors++;
				$display("%0t table row %0d: expected status %0d actual %p", $realtime, i,
					dir_rows[i].st, last_rec);
			end
		end
		// empty archive, good sum
		send_header(0);
		send_sum_tail(0);
		// short: eof inside the sum
		send_header(0);
		send_byte(8'h00, 1'b1);
		// too many files
		send_header(129);
		send_byte(8'h00, 1'b1);
		// two files with zero-length data, trailing bytes
		send_header(2);
		send_entry(8'h00, 1'b0);
		send_entry(8'h00, 1'b1);
		send_sum_tail(2);
		// one file of one sector, cut short inside the data
		send_header(1);
		send_entry(8'h01, 1'b0);
		repeat (12) send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		while (bytes_sent < 150) random_archive();
		quiet = 1'b1;
		random_archive();
		item_valid <= 1'b0;
		while (expected_recs.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("covered %0d bytes, %0d archives, %0d records checked", bytes_sent,
			archives_done, recs_checked);
		$display("status counts: match %0d mismatch %0d unchecked %0d invalid %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
		if (errors == 0)
			$display("scl_archive_to_trdos_image_unit: match");
		else
			$display("scl_archive_to_trdos_image_unit: mismatch");
		$finish;
	end
endmodule
